### src/sfr_pkg.sv
// sfr_pkg: shared constants and controller/datapath interface types for the
// streaming find-and-replace block. No dependencies.
`default_nettype none

package sfr_pkg;

   // Widths fixed by the field definitions
   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 4;
   localparam int CFG_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;

   // Default sizes for the top-level parameters
   localparam int MAX_PATTERN_DEF     = 8;
   localparam int MAX_REPLACEMENT_DEF = 8;

   // Configuration register indexes
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_PATTERN_BYTES      = 2'd0;
   localparam csr_idx_type CSR_PATTERN_LENGTH     = 2'd1;
   localparam csr_idx_type CSR_REPLACEMENT_BYTES  = 2'd2;
   localparam csr_idx_type CSR_REPLACEMENT_LENGTH = 2'd3;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic append;       // take the request byte into the window
      logic clear_count;  // full match: empty the window
      logic repl_start;   // rewind the replacement index
      logic emit_repl;    // load the next replacement byte into the output
      logic emit_drain;   // load the window front byte and shift the window
      logic emit_marker;  // load an end marker that carries no byte
   } sfr_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic matched;      // window equals the whole pattern
      logic rlen_zero;    // replacement is empty
      logic repl_last;    // current replacement byte is the last one
      logic drain_more;   // window front byte has to leave now
      logic next_more;    // another byte would leave after this one
      logic end_flag;     // request in work carries text_end
      logic slot_free;    // output register can take a result this cycle
      logic win_empty;    // window count is zero
   } sfr_status_type;

endpackage

`default_nettype wire

### src/sfr_datapath.sv
// sfr_datapath: configuration registers, match window, prefix compare,
// replacement index and the output register. Depends on sfr_pkg.
`default_nettype none

module sfr_datapath #(
   parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
   parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // configuration writes
   input  wire logic                          csr_valid,
   input  wire sfr_pkg::csr_idx_type          csr_index,
   input  wire logic [sfr_pkg::CFG_DATA_W-1:0] csr_data,
   // request payload
   input  wire logic [sfr_pkg::BYTE_W-1:0]    req_data_byte,
   input  wire logic                          req_text_end,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [sfr_pkg::BYTE_W-1:0]         rsp_out_byte,
   output logic                               rsp_byte_valid,
   output logic                               rsp_run_last,
   output logic                               rsp_output_end,
   // controller link
   input  wire sfr_pkg::sfr_cmd_type          cmd,
   output sfr_pkg::sfr_status_type            status
);
   import sfr_pkg::*;

   localparam int CNT_W = $clog2(MAX_PATTERN + 1);
   localparam int RI_W  = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1;
   localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(MAX_PATTERN - 1);
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_PATTERN);
   localparam logic [LEN_W-1:0] PLEN_MAX = LEN_W'(MAX_PATTERN);
   localparam logic [LEN_W-1:0] RLEN_MAX = LEN_W'(MAX_REPLACEMENT);

   // configuration
   logic [CFG_DATA_W-1:0] pattern_bytes_ff;
   logic [LEN_W-1:0]      pattern_length_ff;
   logic [CFG_DATA_W-1:0] replacement_bytes_ff;
   logic [LEN_W-1:0]      replacement_length_ff;

   // window and control
   logic [BYTE_W-1:0] window_ff [MAX_PATTERN];
   logic [BYTE_W-1:0] window_in [MAX_PATTERN];
   logic [CNT_W-1:0]  window_count_ff, window_count_in;
   logic              end_ff, end_in;
   logic [RI_W-1:0]   repl_idx_ff, repl_idx_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_out_byte_ff, rsp_out_byte_in;
   logic              rsp_byte_valid_ff, rsp_byte_valid_in;
   logic              rsp_run_last_ff, rsp_run_last_in;
   logic              rsp_output_end_ff, rsp_output_end_in;

   // derived values
   logic [LEN_W-1:0]       plen, rlen, count_len, count_m1_len;
   logic [CNT_W-1:0]       wr_pos;
   logic [MAX_PATTERN-1:0] eq, in_win, eq_sh, in_sh;
   logic                   prefix_ok, prefix_sh_ok;
   logic                   repl_last, next_more, slot_free;
   logic [BYTE_W-1:0]      repl_byte;

   // configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff      <= '0;
         pattern_length_ff     <= '0;
         replacement_bytes_ff  <= '0;
         replacement_length_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PATTERN_BYTES:      pattern_bytes_ff      <= csr_data;
            CSR_PATTERN_LENGTH:     pattern_length_ff     <= csr_data[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES:  replacement_bytes_ff  <= csr_data;
            CSR_REPLACEMENT_LENGTH: replacement_length_ff <= csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // saturated lengths
   assign plen = (pattern_length_ff > PLEN_MAX) ? PLEN_MAX : pattern_length_ff;
   assign rlen = (replacement_length_ff > RLEN_MAX) ? RLEN_MAX : replacement_length_ff;
   assign count_len    = LEN_W'(window_count_ff);
   assign count_m1_len = count_len - LEN_W'(1);

   // prefix compare on the window as it stands and on the window shifted by one
   always_comb begin
      eq_sh = '1;
      in_sh = '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         eq[i]     = (window_ff[i] == pattern_bytes_ff[BYTE_W*i +: BYTE_W]);
         in_win[i] = (CNT_W'(i) < window_count_ff);
      end
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
         eq_sh[i] = (window_ff[i+1] == pattern_bytes_ff[BYTE_W*i +: BYTE_W]);
         in_sh[i] = (CNT_W'(i + 1) < window_count_ff);
      end
   end

   assign prefix_ok    = &(eq | ~in_win);
   assign prefix_sh_ok = &(eq_sh | ~in_sh);

   // byte after the current front leaves: more to drain?
   assign next_more = (count_len > LEN_W'(1)) &&
                      (end_ff || !((count_m1_len < plen) && prefix_sh_ok));
   assign repl_last = (LEN_W'(repl_idx_ff) == (rlen - LEN_W'(1)));
   assign repl_byte = replacement_bytes_ff[BYTE_W*repl_idx_ff +: BYTE_W];
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      status.matched    = (count_len == plen) && prefix_ok;
      status.rlen_zero  = (rlen == '0);
      status.repl_last  = repl_last;
      status.drain_more = (window_count_ff != '0) &&
                          (end_ff || !((count_len < plen) && prefix_ok));
      status.next_more  = next_more;
      status.end_flag   = end_ff;
      status.slot_free  = slot_free;
      status.win_empty  = (window_count_ff == '0);
   end

   // window append, front shift and count
   assign wr_pos = (window_count_ff > CNT_CAP) ? CNT_CAP : window_count_ff;

   always_comb begin
      window_in       = window_ff;
      window_count_in = window_count_ff;
      if (cmd.append) begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            if (CNT_W'(i) == wr_pos) begin
               window_in[i] = req_data_byte;
            end
         end
         window_count_in = wr_pos + CNT_W'(1);
      end else if (cmd.clear_count) begin
         window_count_in = '0;
      end else if (cmd.emit_drain) begin
         for (int i = 0; i < MAX_PATTERN - 1; i++) begin
            window_in[i] = window_ff[i+1];
         end
         window_count_in = window_count_ff - CNT_W'(1);
      end
   end

   // end flag and replacement index
   always_comb begin
      end_in      = cmd.append ? req_text_end : end_ff;
      repl_idx_in = repl_idx_ff;
      if (cmd.repl_start) begin
         repl_idx_in = '0;
      end else if (cmd.emit_repl) begin
         repl_idx_in = repl_idx_ff + RI_W'(1);
      end
   end

   // output register load
   always_comb begin
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_out_byte_in   = rsp_out_byte_ff;
      rsp_byte_valid_in = rsp_byte_valid_ff;
      rsp_run_last_in   = rsp_run_last_ff;
      rsp_output_end_in = rsp_output_end_ff;
      if (cmd.emit_repl) begin
         rsp_valid_in      = 1'b1;
         rsp_out_byte_in   = repl_byte;
         rsp_byte_valid_in = 1'b1;
         rsp_run_last_in   = repl_last;
         rsp_output_end_in = end_ff && repl_last;
      end else if (cmd.emit_drain) begin
         rsp_valid_in      = 1'b1;
         rsp_out_byte_in   = window_ff[0];
         rsp_byte_valid_in = 1'b1;
         rsp_run_last_in   = !next_more;
         rsp_output_end_in = end_ff && !next_more;
      end else if (cmd.emit_marker) begin
         rsp_valid_in      = 1'b1;
         rsp_out_byte_in   = '0;
         rsp_byte_valid_in = 1'b0;
         rsp_run_last_in   = 1'b1;
         rsp_output_end_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_count_ff <= '0;
         end_ff          <= 1'b0;
         repl_idx_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         window_count_ff <= window_count_in;
         end_ff          <= end_in;
         repl_idx_ff     <= repl_idx_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      window_ff         <= window_in;
      rsp_out_byte_ff   <= rsp_out_byte_in;
      rsp_byte_valid_ff <= rsp_byte_valid_in;
      rsp_run_last_ff   <= rsp_run_last_in;
      rsp_output_end_ff <= rsp_output_end_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_out_byte_ff;
   assign rsp_byte_valid = rsp_byte_valid_ff;
   assign rsp_run_last   = rsp_run_last_ff;
   assign rsp_output_end = rsp_output_end_ff;

   // at most one result source per cycle
   a_one_emit : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.emit_repl, cmd.emit_drain, cmd.emit_marker}))
      else $error("more than one result source in one cycle");

   // never overwrite a result the receiver has not taken
   a_emit_slot : assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_repl || cmd.emit_drain || cmd.emit_marker) |-> slot_free)
      else $error("result loaded into a full output register");

   // window never holds more bytes than it has entries
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      window_count_ff <= CNT_MAX)
      else $error("window count beyond window depth");

endmodule

`default_nettype wire

### src/sfr_ctrl.sv
// sfr_ctrl: request sequencer for the find-and-replace block. Steps one
// request through check, replace, drain and end-marker phases. Depends on sfr_pkg.
`default_nettype none

module sfr_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire sfr_pkg::sfr_status_type status,
   output sfr_pkg::sfr_cmd_type         cmd
);
   import sfr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_REPLACE,
      ST_DRAIN,
      ST_MARKER
   } state_type;

   state_type state_ff, state_in;
   logic      emitted_ff, emitted_in;

   assign req_ready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      emitted_in = emitted_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.append = 1'b1;
               emitted_in = 1'b0;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.matched) begin
               cmd.clear_count = 1'b1;
               cmd.repl_start  = 1'b1;
               if (!status.rlen_zero) begin
                  state_in = ST_REPLACE;
               end else if (status.end_flag) begin
                  state_in = ST_MARKER;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_REPLACE: begin
            if (status.slot_free) begin
               cmd.emit_repl = 1'b1;
               emitted_in    = 1'b1;
               if (status.repl_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DRAIN: begin
            if (status.drain_more) begin
               if (status.slot_free) begin
                  cmd.emit_drain = 1'b1;
                  emitted_in     = 1'b1;
                  if (!status.next_more) begin
                     state_in = ST_IDLE;
                  end
               end
            end else if (status.end_flag && !emitted_ff) begin
               state_in = ST_MARKER;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MARKER: begin
            if (status.slot_free) begin
               cmd.emit_marker = 1'b1;
               emitted_in      = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         emitted_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         emitted_ff <= emitted_in;
      end
   end

   // a finished end-of-text request leaves the window empty
   a_end_flushed : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_in == ST_IDLE && status.end_flag) |=> status.win_empty)
      else $error("window not empty after end of text");

   // the end marker only stands in for a request that gave no byte
   a_marker_alone : assert property (@(posedge clock) disable iff (reset)
      cmd.emit_marker |-> !emitted_ff)
      else $error("end marker after a byte of the same request");

   // no result is produced while a new request may be taken
   a_idle_quiet : assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !(cmd.emit_repl || cmd.emit_drain || cmd.emit_marker))
      else $error("result produced while waiting for a request");

endmodule

`default_nettype wire

### src/stream_find_replace_core.sv
// stream_find_replace_core: top level of the streaming find-and-replace block.
// Joins sfr_ctrl and sfr_datapath. Depends on sfr_pkg.
//
// Usage:
//   req_*  : one text byte per request, req_text_end on the final byte.
//   rsp_*  : rewritten text, one byte per result; rsp_run_last marks the
//            last result of a request, rsp_output_end the last of the text.
//            A result with rsp_byte_valid low is an end marker with no byte.
//   csr_*  : register writes (0 pattern bytes, 1 pattern length,
//            2 replacement bytes, 3 replacement length); always ready,
//            write only while no request is in work.
// Timing: one request is in work at a time. An accepted request passes
//   from idle through the check state and then, as needed, the replace,
//   drain or end-marker state back to idle; a match with an empty
//   replacement goes from check straight back to idle (or to the
//   end-marker state at end of text). Each result is loaded into the
//   output register, which drives rsp_*. The sequencer loads the output
//   register at most once per cycle, only while it is free; that sets the rate.
// Reset empties the window, clears the configuration and the output register's valid flag.
// A stalled receiver holds the result in the output register and the
// sequencer waits; no result is dropped.
`default_nettype none

module stream_find_replace_core #(
   parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
   parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // configuration
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire sfr_pkg::csr_idx_type           csr_index,
   input  wire logic [sfr_pkg::CFG_DATA_W-1:0] csr_data,
   // requests
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [sfr_pkg::BYTE_W-1:0]     req_data_byte,
   input  wire logic                           req_text_end,
   // results
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [sfr_pkg::BYTE_W-1:0]          rsp_out_byte,
   output logic                                rsp_byte_valid,
   output logic                                rsp_run_last,
   output logic                                rsp_output_end
);
   import sfr_pkg::*;

   sfr_cmd_type    cmd;
   sfr_status_type status;

   // register writes are always accepted
   assign csr_ready = 1'b1;

   sfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sfr_datapath #(
      .MAX_PATTERN     (MAX_PATTERN),
      .MAX_REPLACEMENT (MAX_REPLACEMENT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_data_byte  (req_data_byte),
      .req_text_end   (req_text_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_output_end (rsp_output_end),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

`default_nettype wire

### tb/stream_find_replace_core_tb.sv
`timescale 1ns / 1ps
// stream_find_replace_core_tb: self-checking testbench for the streaming
// find-and-replace core, with its own rewrite predictor and result checker.
// Depends on sfr_pkg and stream_find_replace_core.

module stream_find_replace_core_tb;
   import sfr_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 12;
   localparam int LONG_HOLD    = 300;
   localparam int PHASE_ITEMS  = 25;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              text_end;
   } text_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic              run_last;
      logic              output_end;
   } rewrite_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   // block ports
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_idx_type           csr_index = CSR_PATTERN_BYTES;
   logic [CFG_DATA_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [BYTE_W-1:0]     req_data_byte = '0;
   logic                  req_text_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [BYTE_W-1:0]     rsp_out_byte;
   logic                  rsp_byte_valid;
   logic                  rsp_run_last;
   logic                  rsp_output_end;

   stream_find_replace_core uut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_text_end   (req_text_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_output_end (rsp_output_end)
   );

   // predictor copy of configuration and window
   logic [CFG_DATA_W-1:0] cfg_pattern  = '0;
   logic [LEN_W-1:0]      cfg_pat_len  = '0;
   logic [CFG_DATA_W-1:0] cfg_repl     = '0;
   logic [LEN_W-1:0]      cfg_repl_len = '0;
   logic [BYTE_W-1:0]     win_bytes [0:7];
   int                    win_count = 0;

   text_req_type pending_req_q [$];
   rewrite_type  rewritten_q [$];

   int   fail_count  = 0;
   int   cycle_count = 0;
   logic req_fire    = 1'b0;
   int   send_gap    = 0;
   int   sink_gap    = 0;
   int   hold_left   = 0;
   logic hold_done   = 1'b0;
   logic hold_arm    = 1'b0;
   logic calm        = 1'b0;
   text_req_type drive_item;
   rewrite_type  seen, want;
   logic [BYTE_W-1:0] alpha [0:2];

   function automatic int sat_len(input logic [LEN_W-1:0] v);
      return (v > 8) ? 8 : int'(v);
   endfunction

   function automatic bit window_is_prefix(input int n);
      for (int i = 0; i < n; i++)
         if (win_bytes[i] != cfg_pattern[8*i +: 8]) return 1'b0;
      return 1'b1;
   endfunction

   // expected rewrite of one accepted request
   task automatic predict_rewrite(input logic [BYTE_W-1:0] in_byte, input logic in_end);
      rewrite_type res [0:8];
      int plen, rlen, n, k, i;
      plen = sat_len(cfg_pat_len);
      rlen = sat_len(cfg_repl_len);
      k = 0;
      n = (win_count > 7) ? 7 : win_count;
      win_bytes[n] = in_byte;
      n = n + 1;
      if (n == plen && window_is_prefix(n)) begin
         // full match: replacement out, window empties
         for (i = 0; i < rlen; i++) begin
            res[k] = {cfg_repl[8*i +: 8], 1'b1, 1'b0, 1'b0};
            k = k + 1;
         end
         n = 0;
      end else begin
         // front bytes leave until the rest is a proper prefix
         while (n > 0 && !(n < plen && window_is_prefix(n))) begin
            res[k] = {win_bytes[0], 1'b1, 1'b0, 1'b0};
            k = k + 1;
            for (i = 0; i < n - 1; i++) win_bytes[i] = win_bytes[i + 1];
            n = n - 1;
         end
      end
      if (in_end) begin
         // end of text flushes the window, or yields a bare end marker
         for (i = 0; i < n; i++) begin
            res[k] = {win_bytes[i], 1'b1, 1'b0, 1'b0};
            k = k + 1;
         end
         n = 0;
         if (k == 0) begin
            res[k] = {8'h00, 1'b0, 1'b0, 1'b0};
            k = k + 1;
         end
      end
      if (k > 0) begin
         res[k-1].run_last   = 1'b1;
         res[k-1].output_end = in_end;
      end
      for (i = 0; i < k; i++) rewritten_q.push_back(res[i]);
      win_count = n;
   endtask

   // request capture, prediction and result checking
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, rewritten_q.size());
         $display("end of test: mismatches");
         $finish;
      end
      req_fire <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_out_byte, rsp_byte_valid, rsp_run_last, rsp_output_end};
            if (rewritten_q.size() == 0) begin
               $display("%0t: unexpected result byte=%h valid=%b last=%b end=%b",
                        $time, seen.out_byte, seen.byte_valid, seen.run_last,
                        seen.output_end);
               fail_count <= fail_count + 1;
            end else begin
               want = rewritten_q.pop_front();
               if (want !== seen) begin
                  $display("%0t: mismatch expected %h/%b/%b/%b got %h/%b/%b/%b",
                           $time, want.out_byte, want.byte_valid, want.run_last,
                           want.output_end, seen.out_byte, seen.byte_valid,
                           seen.run_last, seen.output_end);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) predict_rewrite(req_data_byte, req_text_end);
      end
   end

   // request driver with random gap bursts
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap > 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            send_gap  <= int'($urandom_range(0, 7));
            req_valid <= 1'b0;
         end else if (pending_req_q.size() > 0) begin
            drive_item     = pending_req_q.pop_front();
            req_valid     <= 1'b1;
            req_data_byte <= drive_item.data_byte;
            req_text_end  <= drive_item.text_end;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result sink: random stall bursts, and one long hold-off once armed
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_arm && !hold_done) begin
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
         rsp_ready <= 1'b0;
      end else if (sink_gap > 0) begin
         sink_gap  <= sink_gap - 1;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         sink_gap  <= int'($urandom_range(0, 7));
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic write_reg(input csr_idx_type idx, input logic [CFG_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PATTERN_BYTES:      cfg_pattern  = value;
         CSR_PATTERN_LENGTH:     cfg_pat_len  = value[LEN_W-1:0];
         CSR_REPLACEMENT_BYTES:  cfg_repl     = value;
         CSR_REPLACEMENT_LENGTH: cfg_repl_len = value[LEN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // all four registers; unused upper bits of the lengths carry noise
   task automatic set_config(input logic [CFG_DATA_W-1:0] pat, input logic [LEN_W-1:0] plen,
                             input logic [CFG_DATA_W-1:0] repl,
                             input logic [LEN_W-1:0] rlen);
      logic [CFG_DATA_W-1:0] lv;
      write_reg(CSR_PATTERN_BYTES, pat);
      lv = {$urandom, $urandom};
      lv[LEN_W-1:0] = plen;
      write_reg(CSR_PATTERN_LENGTH, lv);
      write_reg(CSR_REPLACEMENT_BYTES, repl);
      lv = {$urandom, $urandom};
      lv[LEN_W-1:0] = rlen;
      write_reg(CSR_REPLACEMENT_LENGTH, lv);
      @(posedge clock);
      #1;
   endtask

   // sender pause: everything accepted and answered, then the no-result slack
   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (pending_req_q.size() != 0 || req_valid || rewritten_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      #1;
   endtask

   task automatic push_byte(input logic [BYTE_W-1:0] b, input logic e);
      pending_req_q.push_back({b, e});
   endtask

   // random text: mostly pattern prefixes and alphabet bytes, some noise; all noise with an empty pattern
   task automatic fill_text(input int count);
      int left, plen, cut, i, r;
      left = count;
      plen = sat_len(cfg_pat_len);
      while (left > 0) begin
         r = int'($urandom_range(0, 9));
         if (plen > 0 && r < 5) begin
            cut = ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, plen)) : plen;
            for (i = 0; i < cut && left > 0; i++) begin
               push_byte(cfg_pattern[8*i +: 8], $urandom_range(0, 11) == 0);
               left = left - 1;
            end
         end else if (plen > 0 && r < 8) begin
            push_byte(alpha[$urandom_range(0, 2)], $urandom_range(0, 11) == 0);
            left = left - 1;
         end else begin
            push_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 11) == 0);
            left = left - 1;
         end
      end
   endtask

   initial begin
      logic [CFG_DATA_W-1:0] pat;
      logic [LEN_W-1:0]      plen, rlen;
      int                    i, ph;
      for (i = 0; i < 8; i++) win_bytes[i] = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      // reset configuration passes data straight through
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b1);
      wait_idle();

      // "abc" -> "XY": match, broken prefix, stray byte, flush at end
      set_config(64'h0000_0000_0063_6261, 4'd3, 64'h0000_0000_0000_5958, 4'd2);
      push_byte(8'h61, 1'b0); push_byte(8'h62, 1'b0); push_byte(8'h63, 1'b0);
      push_byte(8'h61, 1'b0); push_byte(8'h62, 1'b0); push_byte(8'h64, 1'b0);
      push_byte(8'h78, 1'b0);
      push_byte(8'h61, 1'b0); push_byte(8'h62, 1'b1);
      wait_idle();

      // oversized lengths saturate: 8-byte pattern, 8-byte replacement
      set_config({$urandom, $urandom}, 4'd15, {$urandom, $urandom}, 4'd15);
      for (i = 0; i < 8; i++) push_byte(cfg_pattern[8*i +: 8], i == 7);
      wait_idle();

      // empty replacement on the final byte gives a bare end marker
      set_config(64'h0000_0000_0000_6261, 4'd2, {$urandom, $urandom}, 4'd0);
      push_byte(8'h61, 1'b0); push_byte(8'h62, 1'b1);
      // window left holding a byte while the pattern is switched off
      push_byte(8'h61, 1'b0);
      wait_idle();
      set_config(cfg_pattern, 4'd0, cfg_repl, 4'd0);
      push_byte(8'h78, 1'b1);
      wait_idle();

      // random phases over a spread of settings
      for (ph = 0; ph < 10; ph++) begin
         for (i = 0; i < 3; i++) alpha[i] = BYTE_W'($urandom_range(0, 255));
         for (i = 0; i < 8; i++) pat[8*i +: 8] = alpha[$urandom_range(0, 2)];
         case (ph)
            0:       begin plen = 4'd1; rlen = 4'd8; end
            1:       begin plen = 4'd8; rlen = 4'd0; end
            2:       begin plen = 4'd0; rlen = LEN_W'($urandom_range(0, 8)); end
            3:       begin
               plen = LEN_W'($urandom_range(9, 15));
               rlen = LEN_W'($urandom_range(9, 15));
            end
            4:       begin plen = 4'd2; rlen = 4'd8; end
            default: begin
               plen = LEN_W'($urandom_range(1, 8));
               rlen = LEN_W'($urandom_range(0, 8));
            end
         endcase
         set_config(pat, plen, {$urandom, $urandom}, rlen);
         if (ph == 4) hold_arm = 1'b1;
         if (ph == 9) calm = 1'b1;
         fill_text(PHASE_ITEMS);
         if (ph == 9) push_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
         wait_idle();
      end

      repeat (2 * DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
